// ===== rtl/htd_pkg.sv =====
package htd_pkg;

   // Field widths of the request and response words.
   localparam int CODE_W     = 16;
   localparam int LEN_W      = 5;
   localparam int SYM_W      = 8;
   localparam int BYTE_W     = 8;
   localparam int CODE_IDX_W = 4;
   localparam int BIT_CNT_W  = 4;

   // Longest code that a load walks; longer lengths saturate here.
   localparam logic [LEN_W-1:0] MAX_CODE_LEN = 5'd16;

   // Number of stream bits in one decode word.
   localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;

   // Request action codes.
   localparam logic ACT_LOAD = 1'b0;

   typedef enum logic [1:0] {
      ST_SYMBOL  = 2'd0,
      ST_INVALID = 2'd1,
      ST_LOADED  = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LD_STEP,
      S_LD_FETCH,
      S_LD_DONE,
      S_DC_FETCH,
      S_DC_STEP,
      S_DC_CHECK,
      S_DC_FLUSH
   } state_type;

   // One result word handed from the walker to the output register.
   typedef struct packed {
      logic             valid;
      logic [SYM_W-1:0] symbol;
      status_type       status;
      logic             last;
   } emit_type;

endpackage

// ===== rtl/htd_if.sv =====
interface htd_req_if;
   logic                           valid;
   logic                           ready;
   logic                           action;
   logic [htd_pkg::CODE_W-1:0]     code_bits;
   logic [htd_pkg::LEN_W-1:0]      code_len;
   logic [htd_pkg::SYM_W-1:0]      code_symbol;
   logic [htd_pkg::BYTE_W-1:0]     data_byte;

   modport source (
      output valid, action, code_bits, code_len, code_symbol, data_byte,
      input  ready
   );
   modport sink (
      input  valid, action, code_bits, code_len, code_symbol, data_byte,
      output ready
   );
endinterface

interface htd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [htd_pkg::SYM_W-1:0]  symbol;
   logic [1:0]                 status;
   logic                       last;

   modport source (
      output valid, symbol, status, last,
      input  ready
   );
   modport sink (
      input  valid, symbol, status, last,
      output ready
   );
endinterface

// ===== rtl/htd_node_ram.sv =====
module htd_node_ram #(
   parameter int DEPTH = 512,
   parameter int WIDTH = 26
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next read, so a stalled walker can keep using it.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/htd_ctrl.sv =====
module htd_ctrl #(
   parameter int NODE_COUNT = 512
) (
   input  logic                           clock,
   input  logic                           reset,
   htd_req_if.sink                        req,
   output logic                           ram_rd_en,
   output logic [$clog2(NODE_COUNT)-1:0]  ram_rd_addr,
   input  logic [2*$clog2(NODE_COUNT)+htd_pkg::SYM_W-1:0] ram_rd_data,
   output logic                           ram_wr_en,
   output logic [$clog2(NODE_COUNT)-1:0]  ram_wr_addr,
   output logic [2*$clog2(NODE_COUNT)+htd_pkg::SYM_W-1:0] ram_wr_data,
   output htd_pkg::emit_type              emit,
   input  logic                           emit_ready
);

   localparam int NW = $clog2(NODE_COUNT);
   localparam int UW = $clog2(NODE_COUNT + 1);
   localparam int SW = htd_pkg::SYM_W;
   localparam logic [UW-1:0] FULL_CNT = UW'(NODE_COUNT);

   htd_pkg::state_type  state_ff, state_in;
   logic [NW-1:0]       cur_left_ff, cur_left_in;
   logic [NW-1:0]       cur_right_ff, cur_right_in;
   logic [SW-1:0]       cur_sym_ff, cur_sym_in;
   logic [NW-1:0]       cur_addr_ff, cur_addr_in;
   logic [NW-1:0]       root_left_ff, root_left_in;
   logic [NW-1:0]       root_right_ff, root_right_in;
   logic [SW-1:0]       root_sym_ff, root_sym_in;
   logic [NW-1:0]       walk_ff, walk_in;
   logic [UW-1:0]       used_ff, used_in;
   logic [htd_pkg::LEN_W-1:0]     step_ff, step_in;
   logic [htd_pkg::CODE_W-1:0]    code_ff, code_in;
   logic [SW-1:0]                 load_sym_ff, load_sym_in;
   logic [htd_pkg::BYTE_W-1:0]    byte_ff, byte_in;
   logic [htd_pkg::BIT_CNT_W-1:0] bits_ff, bits_in;
   logic [NW-1:0]       child_ff, child_in;
   htd_pkg::status_type done_st_ff, done_st_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [SW-1:0]       pend_sym_ff, pend_sym_in;
   htd_pkg::status_type pend_st_ff, pend_st_in;

   logic [NW-1:0]                 rd_left, rd_right;
   logic [SW-1:0]                 rd_sym;
   logic [htd_pkg::CODE_IDX_W-1:0] step_m1;
   logic [NW-1:0]                 child;
   logic                          wb_en;
   logic [NW-1:0]                 wb_left, wb_right;
   logic [SW-1:0]                 wb_sym;
   logic                          adv;

   assign {rd_left, rd_right, rd_sym} = ram_rd_data;
   assign step_m1 = htd_pkg::CODE_IDX_W'(step_ff - htd_pkg::LEN_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= htd_pkg::S_IDLE;
         root_left_ff  <= '0;
         root_right_ff <= '0;
         root_sym_ff   <= '0;
         walk_ff       <= '0;
         used_ff       <= UW'(1);
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         root_left_ff  <= root_left_in;
         root_right_ff <= root_right_in;
         root_sym_ff   <= root_sym_in;
         walk_ff       <= walk_in;
         used_ff       <= used_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_left_ff  <= cur_left_in;
      cur_right_ff <= cur_right_in;
      cur_sym_ff   <= cur_sym_in;
      cur_addr_ff  <= cur_addr_in;
      step_ff      <= step_in;
      code_ff      <= code_in;
      load_sym_ff  <= load_sym_in;
      byte_ff      <= byte_in;
      bits_ff      <= bits_in;
      child_ff     <= child_in;
      done_st_ff   <= done_st_in;
      pend_sym_ff  <= pend_sym_in;
      pend_st_ff   <= pend_st_in;
   end

   always_comb begin
      state_in      = state_ff;
      cur_left_in   = cur_left_ff;
      cur_right_in  = cur_right_ff;
      cur_sym_in    = cur_sym_ff;
      cur_addr_in   = cur_addr_ff;
      root_left_in  = root_left_ff;
      root_right_in = root_right_ff;
      root_sym_in   = root_sym_ff;
      walk_in       = walk_ff;
      used_in       = used_ff;
      step_in       = step_ff;
      code_in       = code_ff;
      load_sym_in   = load_sym_ff;
      byte_in       = byte_ff;
      bits_in       = bits_ff;
      child_in      = child_ff;
      done_st_in    = done_st_ff;
      pend_valid_in = pend_valid_ff;
      pend_sym_in   = pend_sym_ff;
      pend_st_in    = pend_st_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = cur_addr_ff;
      ram_wr_data   = '0;
      emit          = '0;
      req.ready     = 1'b0;
      wb_en         = 1'b0;
      wb_left       = cur_left_ff;
      wb_right      = cur_right_ff;
      wb_sym        = cur_sym_ff;
      adv           = 1'b1;
      child         = byte_ff[htd_pkg::BYTE_W-1] ? cur_right_ff : cur_left_ff;

      case (state_ff)
         htd_pkg::S_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               if (req.action == htd_pkg::ACT_LOAD) begin
                  code_in     = req.code_bits;
                  load_sym_in = req.code_symbol;
                  step_in     = (req.code_len > htd_pkg::MAX_CODE_LEN) ?
                                htd_pkg::MAX_CODE_LEN : req.code_len;
                  cur_left_in  = root_left_ff;
                  cur_right_in = root_right_ff;
                  cur_sym_in   = root_sym_ff;
                  cur_addr_in  = '0;
                  state_in     = htd_pkg::S_LD_STEP;
               end else begin
                  byte_in = req.data_byte;
                  bits_in = htd_pkg::BITS_PER_BYTE;
                  if (walk_ff == '0) begin
                     cur_left_in  = root_left_ff;
                     cur_right_in = root_right_ff;
                     cur_sym_in   = root_sym_ff;
                     state_in     = htd_pkg::S_DC_STEP;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = walk_ff;
                     state_in    = htd_pkg::S_DC_FETCH;
                  end
               end
            end
         end

         htd_pkg::S_LD_STEP: begin
            if (step_ff == '0) begin
               // End of the code: the node in hand takes the symbol.
               wb_en      = 1'b1;
               wb_sym     = load_sym_ff;
               done_st_in = htd_pkg::ST_LOADED;
               state_in   = htd_pkg::S_LD_DONE;
            end else begin
               child = code_ff[step_m1] ? cur_right_ff : cur_left_ff;
               if (child != '0) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = child;
                  cur_addr_in = child;
                  step_in     = step_ff - htd_pkg::LEN_W'(1);
                  state_in    = htd_pkg::S_LD_FETCH;
               end else if (used_ff == FULL_CNT) begin
                  // Keep whatever was allocated so far, store no symbol.
                  wb_en      = 1'b1;
                  done_st_in = htd_pkg::ST_FULL;
                  state_in   = htd_pkg::S_LD_DONE;
               end else begin
                  // Link a fresh node and carry on with it held in registers.
                  wb_en = 1'b1;
                  if (code_ff[step_m1]) begin
                     wb_right = used_ff[NW-1:0];
                  end else begin
                     wb_left = used_ff[NW-1:0];
                  end
                  cur_left_in  = '0;
                  cur_right_in = '0;
                  cur_sym_in   = '0;
                  cur_addr_in  = used_ff[NW-1:0];
                  used_in      = used_ff + UW'(1);
                  step_in      = step_ff - htd_pkg::LEN_W'(1);
               end
            end
         end

         htd_pkg::S_LD_FETCH: begin
            cur_left_in  = rd_left;
            cur_right_in = rd_right;
            cur_sym_in   = rd_sym;
            state_in     = htd_pkg::S_LD_STEP;
         end

         htd_pkg::S_LD_DONE: begin
            emit.valid  = 1'b1;
            emit.status = done_st_ff;
            emit.last   = 1'b1;
            if (emit_ready) begin
               state_in = htd_pkg::S_IDLE;
            end
         end

         htd_pkg::S_DC_FETCH: begin
            cur_left_in  = rd_left;
            cur_right_in = rd_right;
            cur_sym_in   = rd_sym;
            state_in     = htd_pkg::S_DC_STEP;
         end

         htd_pkg::S_DC_STEP: begin
            if (bits_ff == '0) begin
               state_in = pend_valid_ff ? htd_pkg::S_DC_FLUSH : htd_pkg::S_IDLE;
            end else if (child == '0) begin
               // Missing child: report it and restart from the root.
               if (pend_valid_ff) begin
                  emit.valid  = 1'b1;
                  emit.symbol = pend_sym_ff;
                  emit.status = pend_st_ff;
                  adv         = emit_ready;
               end
               if (adv) begin
                  pend_valid_in = 1'b1;
                  pend_sym_in   = '0;
                  pend_st_in    = htd_pkg::ST_INVALID;
                  walk_in       = '0;
                  cur_left_in   = root_left_ff;
                  cur_right_in  = root_right_ff;
                  cur_sym_in    = root_sym_ff;
                  byte_in       = byte_ff << 1;
                  bits_in       = bits_ff - htd_pkg::BIT_CNT_W'(1);
               end
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = child;
               child_in    = child;
               state_in    = htd_pkg::S_DC_CHECK;
            end
         end

         htd_pkg::S_DC_CHECK: begin
            if (rd_left == '0 && rd_right == '0) begin
               if (pend_valid_ff) begin
                  emit.valid  = 1'b1;
                  emit.symbol = pend_sym_ff;
                  emit.status = pend_st_ff;
                  adv         = emit_ready;
               end
               if (adv) begin
                  pend_valid_in = 1'b1;
                  pend_sym_in   = rd_sym;
                  pend_st_in    = htd_pkg::ST_SYMBOL;
                  walk_in       = '0;
                  cur_left_in   = root_left_ff;
                  cur_right_in  = root_right_ff;
                  cur_sym_in    = root_sym_ff;
                  byte_in       = byte_ff << 1;
                  bits_in       = bits_ff - htd_pkg::BIT_CNT_W'(1);
                  state_in      = htd_pkg::S_DC_STEP;
               end
            end else begin
               walk_in      = child_ff;
               cur_left_in  = rd_left;
               cur_right_in = rd_right;
               cur_sym_in   = rd_sym;
               byte_in      = byte_ff << 1;
               bits_in      = bits_ff - htd_pkg::BIT_CNT_W'(1);
               state_in     = htd_pkg::S_DC_STEP;
            end
         end

         htd_pkg::S_DC_FLUSH: begin
            emit.valid  = 1'b1;
            emit.symbol = pend_sym_ff;
            emit.status = pend_st_ff;
            emit.last   = 1'b1;
            if (emit_ready) begin
               pend_valid_in = 1'b0;
               state_in      = htd_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = htd_pkg::S_IDLE;
         end
      endcase

      // The root lives in flip-flops; every other node is written to the table.
      if (wb_en) begin
         if (cur_addr_ff == '0) begin
            root_left_in  = wb_left;
            root_right_in = wb_right;
            root_sym_in   = wb_sym;
         end else begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cur_addr_ff;
            ram_wr_data = {wb_left, wb_right, wb_sym};
         end
      end
   end

endmodule

// ===== rtl/huffman_tree_decoder_unit.sv =====
// Channel  Dir  Words carried
// req      in   action, code_bits, code_len, code_symbol, data_byte
// rsp      out  symbol, status, last
//
// A load word is accepted in the idle state. It then takes a step state for each code
// bit that allocates a node and a step and a fetch state for each bit that follows an
// existing node, since the walker waits for the node table read. The walker then
// stores the symbol, or stops without it once the table is full, and sends the result.
// A decode word is accepted and then fetches the walk node when the previous word
// stopped below the root. Each bit whose child is missing takes a step state and each
// bit whose child exists takes a step and a check state. A last step notices the end
// of the word, and the flush state sends the last result if one is pending.
// Synchronous reset empties the tree at once: the root sits in flip-flops and
// every other node is written when it is allocated, so no clearing pass runs.
// A full output register stalls the walker only when a further result must go
// out; the request side stays blocked until the current word is finished.
module huffman_tree_decoder_unit #(
   parameter int NODE_COUNT = 512
) (
   input  logic       clock,
   input  logic       reset,
   htd_req_if.sink    req,
   htd_rsp_if.source  rsp
);

   localparam int NW = $clog2(NODE_COUNT);
   localparam int DW = 2 * NW + htd_pkg::SYM_W;

   logic                ram_rd_en;
   logic [NW-1:0]       ram_rd_addr;
   logic [DW-1:0]       ram_rd_data;
   logic                ram_wr_en;
   logic [NW-1:0]       ram_wr_addr;
   logic [DW-1:0]       ram_wr_data;
   htd_pkg::emit_type   emit;
   logic                emit_ready;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [htd_pkg::SYM_W-1:0]   rsp_symbol_ff;
   htd_pkg::status_type         rsp_status_ff;
   logic                        rsp_last_ff;

   // Node table: {left child, right child, symbol}; index zero is never used
   // in memory, since the root is kept in registers inside the walker.
   htd_node_ram #(
      .DEPTH (NODE_COUNT),
      .WIDTH (DW)
   ) u_node_ram (
      .clock   (clock),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data)
   );

   // Walker: loads codes into the tree and decodes stream bits through it.
   htd_ctrl #(
      .NODE_COUNT (NODE_COUNT)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .emit        (emit),
      .emit_ready  (emit_ready)
   );

   // Output register. A new word may enter in the same cycle the old one leaves.
   assign emit_ready = !rsp_valid_ff || rsp.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit.valid && emit_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid && emit_ready) begin
         rsp_symbol_ff <= emit.symbol;
         rsp_status_ff <= emit.status;
         rsp_last_ff   <= emit.last;
      end
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.symbol = rsp_symbol_ff;
   assign rsp.status = rsp_status_ff;
   assign rsp.last   = rsp_last_ff;

   // While the walker takes requests it must have nothing left to send.
   a_idle_no_emit : assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !emit.valid)
      else $error("walker offers a result while accepting a request");

   // A taken request drops ready in the following cycle, before the next is taken.
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("request accepted while the previous one is in progress");

   // A result handed over by the walker shows up on the output next cycle.
   a_emit_lands : assert property (@(posedge clock) disable iff (reset)
      (emit.valid && emit_ready) |=> rsp.valid)
      else $error("accepted result did not reach the output register");

   // Reset leaves the output empty.
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp.valid)
      else $error("output valid right after reset");

endmodule

// ===== tb/huffman_tree_decoder_unit_tb.sv =====
`timescale 1ns / 1ps

module huffman_tree_decoder_unit_tb;

   localparam int NODE_COUNT     = 512;
   localparam int CLOCK_HALF     = 4;
   localparam int RESET_CYCLES   = 11;
   localparam int GAP_PERCENT    = 32;
   localparam int CALM_FROM      = 60;
   localparam int CALM_TO        = 140;
   localparam int HOLD_AT        = 220;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 60;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int ROUNDS         = 7;
   localparam int FILL_LOADS     = 40;

   localparam logic ACT_DECODE = ~htd_pkg::ACT_LOAD;

   // One request word as the sender offers it.
   typedef struct packed {
      logic                       action;
      logic [htd_pkg::CODE_W-1:0] code_bits;
      logic [htd_pkg::LEN_W-1:0]  code_len;
      logic [htd_pkg::SYM_W-1:0]  code_symbol;
      logic [htd_pkg::BYTE_W-1:0] data_byte;
   } request_word_type;

   // One response word as the block should return it.
   typedef struct packed {
      logic [htd_pkg::SYM_W-1:0] symbol;
      htd_pkg::status_type       status;
      logic                      last;
   } result_word_type;

   logic clock;
   logic reset;

   htd_req_if req_bus ();
   htd_rsp_if rsp_bus ();

   huffman_tree_decoder_unit #(
      .NODE_COUNT(NODE_COUNT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req  (req_bus.sink),
      .rsp  (rsp_bus.source)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // Words waiting to be offered, and the responses that the accepted words
   // must still produce, oldest first.
   request_word_type words_to_send[$];
   result_word_type  tree_results_q[$];

   // Our own copy of the code tree. A child index of zero means the child is
   // absent; the root is never anybody's child, so zero is free for that.
   logic [8:0]                kid_left    [NODE_COUNT];
   logic [8:0]                kid_right   [NODE_COUNT];
   logic [htd_pkg::SYM_W-1:0] leaf_symbol [NODE_COUNT];
   int                        free_node;
   logic [8:0]                walk_at;

   // Codes handed to the block so far; encoded streams are built from them.
   logic [htd_pkg::CODE_W-1:0] known_bits[$];
   int                         known_len[$];
   bit                         stream_bits[$];

   int               req_count;
   int               rsp_count;
   int               mismatches;
   int               idle_cycles;
   int               hold_left;
   bit               hold_done;
   request_word_type in_flight;

   // A stretch of the run in which neither side inserts gaps.
   wire no_gaps = (req_count >= CALM_FROM) && (req_count < CALM_TO);

   // ------------------------------------------------------------------
   // Tree predictor
   // ------------------------------------------------------------------

   // A load walks the code from its most significant valid bit. Missing
   // children are allocated in order from the free counter. When no node is
   // left the walk stops right there: nodes already allocated for this code
   // stay, but the symbol is not stored. Lengths above the maximum saturate,
   // and a zero length just writes the root's symbol, which is never emitted.
   task automatic apply_code_load(input request_word_type w);
      int                  depth;
      logic [8:0]          at;
      logic [8:0]          nxt;
      htd_pkg::status_type outcome;
      result_word_type     r;
      depth   = (w.code_len > htd_pkg::MAX_CODE_LEN) ? int'(htd_pkg::MAX_CODE_LEN)
                                                     : int'(w.code_len);
      at      = '0;
      outcome = htd_pkg::ST_LOADED;
      for (int i = depth; i > 0 && outcome == htd_pkg::ST_LOADED; i--) begin
         nxt = w.code_bits[i-1] ? kid_right[at] : kid_left[at];
         if (nxt == '0) begin
            if (free_node >= NODE_COUNT) begin
               outcome = htd_pkg::ST_FULL;
            end else begin
               nxt              = 9'(free_node);
               kid_left[nxt]    = '0;
               kid_right[nxt]   = '0;
               leaf_symbol[nxt] = '0;
               if (w.code_bits[i-1]) begin
                  kid_right[at] = nxt;
               end else begin
                  kid_left[at] = nxt;
               end
               free_node++;
            end
         end
         if (outcome == htd_pkg::ST_LOADED) begin
            at = nxt;
         end
      end
      if (outcome == htd_pkg::ST_LOADED) begin
         leaf_symbol[at] = w.code_symbol;
      end
      r.symbol = '0;
      r.status = outcome;
      r.last   = 1'b1;
      tree_results_q.push_back(r);
   endtask

   // A decode word walks eight bits, bit 7 first, from wherever the previous
   // word left off. Reaching a node with no children emits its symbol; a step
   // to an absent child emits an invalid-path response. Both send the walk
   // back to the root. Only the final response of the word carries last, so
   // each response is held back until we know whether another follows.
   task automatic apply_data_byte(input logic [htd_pkg::BYTE_W-1:0] data);
      logic [8:0]      nxt;
      result_word_type held;
      bit              have;
      have = 1'b0;
      held = '0;
      for (int i = htd_pkg::BYTE_W - 1; i >= 0; i--) begin
         nxt = data[i] ? kid_right[walk_at] : kid_left[walk_at];
         if (nxt == '0 || (kid_left[nxt] == '0 && kid_right[nxt] == '0)) begin
            if (have) begin
               tree_results_q.push_back(held);
            end
            held.symbol = (nxt == '0) ? '0 : leaf_symbol[nxt];
            held.status = (nxt == '0) ? htd_pkg::ST_INVALID : htd_pkg::ST_SYMBOL;
            held.last   = 1'b0;
            have        = 1'b1;
            walk_at     = '0;
         end else begin
            walk_at = nxt;
         end
      end
      if (have) begin
         held.last = 1'b1;
         tree_results_q.push_back(held);
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus builders
   // ------------------------------------------------------------------

   // Fields that the action does not use carry random junk, so that every
   // bit of every field toggles.
   task automatic queue_load(input logic [htd_pkg::CODE_W-1:0] bits,
                             input logic [htd_pkg::LEN_W-1:0]  len,
                             input logic [htd_pkg::SYM_W-1:0]  sym);
      request_word_type w;
      w.action      = htd_pkg::ACT_LOAD;
      w.code_bits   = bits;
      w.code_len    = len;
      w.code_symbol = sym;
      w.data_byte   = htd_pkg::BYTE_W'($urandom_range(255));
      words_to_send.push_back(w);
      if (len >= 1 && len <= htd_pkg::MAX_CODE_LEN) begin
         known_bits.push_back(bits);
         known_len.push_back(int'(len));
      end
   endtask

   task automatic queue_decode(input logic [htd_pkg::BYTE_W-1:0] data);
      request_word_type w;
      w.action      = ACT_DECODE;
      w.code_bits   = htd_pkg::CODE_W'($urandom_range(16'hFFFF));
      w.code_len    = htd_pkg::LEN_W'($urandom_range(31));
      w.code_symbol = htd_pkg::SYM_W'($urandom_range(255));
      w.data_byte   = data;
      words_to_send.push_back(w);
   endtask

   // Next byte of a stream built from the codes queued for loading, or of random bits
   // while none is known, cut into bytes regardless of code boundaries.
   task automatic queue_stream_byte();
      int                         pick;
      logic [htd_pkg::CODE_W-1:0] code;
      logic [htd_pkg::BYTE_W-1:0] data;
      while (stream_bits.size() < htd_pkg::BYTE_W) begin
         if (known_len.size() == 0) begin
            stream_bits.push_back(bit'($urandom_range(1)));
         end else begin
            pick = $urandom_range(known_len.size() - 1);
            code = known_bits[pick];
            for (int b = known_len[pick] - 1; b >= 0; b--) begin
               stream_bits.push_back(code[b]);
            end
         end
      end
      for (int b = htd_pkg::BYTE_W - 1; b >= 0; b--) begin
         data[b] = stream_bits.pop_front();
      end
      queue_decode(data);
   endtask

   // One round: a few new codes, mostly short, now and then long, empty or
   // over-long, followed by a stream that mostly uses the known codes.
   task automatic queue_round();
      int pick;
      int len;
      for (int k = 0; k < 4; k++) begin
         pick = $urandom_range(19);
         if (pick == 0) begin
            len = 0;
         end else if (pick == 1) begin
            len = $urandom_range(31, 17);
         end else if (pick < 5) begin
            len = $urandom_range(16, 9);
         end else begin
            len = $urandom_range(8, 1);
         end
         queue_load(htd_pkg::CODE_W'($urandom_range(16'hFFFF)), htd_pkg::LEN_W'(len),
                    htd_pkg::SYM_W'($urandom_range(255)));
      end
      for (int k = 0; k < 22; k++) begin
         if ($urandom_range(99) < 85) begin
            queue_stream_byte();
         end else begin
            queue_decode(htd_pkg::BYTE_W'($urandom_range(255)));
         end
      end
   endtask

   // Blocks the calling process until every queued word has been taken and
   // every predicted response has come back.
   task automatic wait_for_quiet();
      while (words_to_send.size() != 0 || req_bus.valid || tree_results_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic compare_field(input string label, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         mismatches++;
      end
   endtask

   // ------------------------------------------------------------------
   // Sender: offers the next queued word, with random gaps. The predictor
   // runs on the word that was just accepted, before the next one is taken.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            if (in_flight.action == htd_pkg::ACT_LOAD) begin
               apply_code_load(in_flight);
            end else begin
               apply_data_byte(in_flight.data_byte);
            end
            req_count <= req_count + 1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (words_to_send.size() != 0 &&
                (no_gaps || $urandom_range(99) >= GAP_PERCENT)) begin
               in_flight             = words_to_send.pop_front();
               req_bus.valid       <= 1'b1;
               req_bus.action      <= in_flight.action;
               req_bus.code_bits   <= in_flight.code_bits;
               req_bus.code_len    <= in_flight.code_len;
               req_bus.code_symbol <= in_flight.code_symbol;
               req_bus.data_byte   <= in_flight.data_byte;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: checks each accepted response against the oldest prediction
   // and throttles ready. Once, at a fixed point in the request count, it
   // holds ready low for a long stretch so the block backs up into its input.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      result_word_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_count <= rsp_count + 1;
            if (tree_results_q.size() == 0) begin
               $display("%0t: response with nothing expected, %s %0d status %0d last %0d",
                        $time, "actual symbol", rsp_bus.symbol, rsp_bus.status,
                        rsp_bus.last);
               mismatches++;
            end else begin
               want = tree_results_q.pop_front();
               compare_field("symbol", want.symbol, rsp_bus.symbol);
               compare_field("status", 8'(want.status), 8'(rsp_bus.status));
               compare_field("last", 8'(want.last), 8'(rsp_bus.last));
            end
         end
         if (!hold_done && req_count == HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= no_gaps || ($urandom_range(99) >= GAP_PERCENT);
         end
      end
   end

   // The run is stuck if neither channel moves a word for too long. The
   // limit covers the long receiver hold plus the slowest load word.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
            $display("FAIL");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.action       = htd_pkg::ACT_LOAD;
      req_bus.code_bits    = '0;
      req_bus.code_len     = '0;
      req_bus.code_symbol  = '0;
      req_bus.data_byte    = '0;
      rsp_bus.ready        = 1'b0;
      req_count            = 0;
      rsp_count            = 0;
      mismatches           = 0;
      idle_cycles          = 0;
      hold_left            = 0;
      hold_done            = 1'b0;
      in_flight            = '0;

      // After reset only the root is in use and it has no children.
      for (int n = 0; n < NODE_COUNT; n++) begin
         kid_left[n]    = '0;
         kid_right[n]   = '0;
         leaf_symbol[n] = '0;
      end
      free_node = 1;
      walk_at   = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. On an empty tree every bit is an invalid path, which
      // gives the largest number of responses for one word.
      queue_decode(8'h00);
      // A complete three-symbol code: 0, 10, 11, with the symbol extremes.
      queue_load(16'h0000, 5'd1, 8'h41);
      queue_load(16'h0002, 5'd2, 8'h00);
      queue_load(16'h0003, 5'd2, 8'hFF);
      queue_decode(8'h00);
      queue_decode(8'hFF);
      // This one ends inside a code, so the walk carries into the next word.
      queue_decode(8'hA5);
      queue_decode(8'h80);
      // A 16-bit code of all ones grows under the leaf for 11, which turns
      // that node into a prefix whose symbol is never emitted again.
      queue_load(16'hFFFF, 5'd16, 8'h5A);
      // The first of these stops halfway down the long code without any
      // response; the second reaches its leaf.
      queue_decode(8'hFF);
      queue_decode(8'hFF);
      // Over-long length saturates to the same 16-bit path.
      queue_load(16'hFFFF, 5'd31, 8'h33);
      // Zero length only touches the root.
      queue_load(16'h0000, 5'd0, 8'hC3);
      // A load between two decode words; the first of them leaves the walk at the root.
      queue_decode(8'hF0);
      queue_load(16'h0001, 5'd3, 8'h77);
      queue_decode(8'h0F);
      queue_decode(8'h55);
      queue_decode(8'h3C);
      queue_load(16'h8000, 5'd17, 8'h99);
      queue_decode(8'hC3);

      for (int r = 0; r < 5; r++) begin
         queue_round();
      end

      // The main sequence waits here until the block has answered everything.
      wait_for_quiet();
      @(negedge clock);

      for (int r = 0; r < 3; r++) begin
         queue_round();
      end
      // Long random codes use up the node table; later loads that need a
      // new node report a full table, while existing paths still load.
      for (int k = 0; k < FILL_LOADS; k++) begin
         queue_load(htd_pkg::CODE_W'($urandom_range(16'hFFFF)), 5'd16,
                    htd_pkg::SYM_W'($urandom_range(255)));
         if (k % 4 == 3) begin
            queue_stream_byte();
         end
      end
      for (int r = 3; r < ROUNDS; r++) begin
         queue_round();
      end

      wait_for_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tree_results_q.size() != 0) begin
         $display("%0t: %0d expected responses never arrived", $time, tree_results_q.size());
      end
      if (mismatches == 0 && tree_results_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
